@@ hw/rtl/btf_pkg.sv @@
`default_nettype none
package btf_pkg;

   localparam int CHUNK_BITS = 4;
   localparam int BYTE_W     = 8;
   localparam int TONE_W     = 16;
   localparam int STEP_W     = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int CHUNKS     = BYTE_W / CHUNK_BITS;
   localparam int CIDX_W     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

   // op slots of one request: header, data chunks, trailing guard
   localparam int SLOT_GUARD  = 0;
   localparam int SLOT_SECOND = 1;
   localparam int SLOT_LEN0   = 2;
   localparam int SLOT_LEN1   = 3;
   localparam int SLOT_DATA   = 4;
   localparam int SLOT_END    = SLOT_DATA + CHUNKS;
   localparam int SLOTS       = SLOT_END + 1;
   localparam int SLOT_W      = $clog2(SLOTS);

   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);
   localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] REG_BASE_TONE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TONE_STEP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_GUARD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_GUARD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SEPARATOR    = 3'd4;

   localparam logic [TONE_W-1:0] RST_BASE_TONE    = 16'd1000;
   localparam logic [STEP_W-1:0] RST_TONE_STEP    = 12'd100;
   localparam logic [TONE_W-1:0] RST_START_GUARD  = 16'd500;
   localparam logic [TONE_W-1:0] RST_SECOND_GUARD = 16'd600;
   localparam logic [TONE_W-1:0] RST_SEPARATOR    = 16'd700;
   localparam logic [TONE_W-1:0] TONE_MAX         = 16'hFFFF;

   typedef struct packed {
      logic [TONE_W-1:0] base_tone;
      logic [STEP_W-1:0] tone_step;
      logic [TONE_W-1:0] start_guard_tone;
      logic [TONE_W-1:0] second_guard_tone;
      logic [TONE_W-1:0] separator_tone;
   } btf_cfg_type;

   typedef struct packed {
      logic [TONE_W-1:0] tone;
      logic              last;
      logic              fresh;   // history cleared before this tone
   } btf_entry_type;

   function automatic logic [TONE_W-1:0] chunk_tone(
      input logic [CHUNK_BITS-1:0] chunk,
      input logic [TONE_W-1:0]     base,
      input logic [STEP_W-1:0]     step
   );
      logic [TONE_W-1:0] prod;
      logic [TONE_W:0]   sum;
      prod = TONE_W'(chunk) * TONE_W'(step);
      sum  = (TONE_W + 1)'(base) + (TONE_W + 1)'(prod);
      return sum[TONE_W] ? TONE_MAX : sum[TONE_W-1:0];
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/btf_ifs.sv @@
`default_nettype none
interface btf_req_if;
   import btf_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              has_data;
   logic              start_of_message;
   logic              end_of_message;
   logic [BYTE_W-1:0] message_length;
   modport source (output valid, data_byte, has_data, start_of_message, end_of_message,
                   message_length, input ready);
   modport sink (input valid, data_byte, has_data, start_of_message, end_of_message,
                 message_length, output ready);
endinterface

interface btf_rsp_if;
   import btf_pkg::*;
   logic              valid;
   logic              ready;
   logic [TONE_W-1:0] tone;
   logic              last_of_run;
   modport source (output valid, tone, last_of_run, input ready);
   modport sink (input valid, tone, last_of_run, output ready);
endinterface

interface btf_csr_if;
   import btf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/byte_to_tone_framer_unit.sv @@
// Byte to tone framer.
// req_ch: one request per message item (data byte, start/end flags, length).
// rsp_ch: one tone per response; last_of_run marks the final tone of a request.
// csr_ch: register writes (index, wdata), always ready; write only while idle.
// A start request yields two guard tones and two length tones, a data byte
// yields one tone per chunk, an end request a trailing guard tone. A separator
// tone precedes any repeat of the previous tone, except a start's first guard.
// The front sequencer emits one tone per cycle into a 4-entry queue while it
// is not full; the back end adds separators and drives a registered output,
// one response per cycle while rsp_ch is ready. The first tone of a request
// passes through the front's slot registers, a queue entry and the output
// register. A data byte with 4-bit chunks yields 2 tones, plus separators.
// The next request is taken in the cycle the previous one's last tone enters
// the queue. Requests with no flags set produce nothing.
// Reset restores register defaults and clears the tone history.
// When rsp_ch stalls, the output holds, the queue fills, then req_ch.ready drops.
`default_nettype none
module byte_to_tone_framer_unit (
   input logic       clock,
   input logic       reset,
   btf_req_if.sink   req_ch,
   btf_rsp_if.source rsp_ch,
   btf_csr_if.sink   csr_ch
);
   import btf_pkg::*;

   btf_cfg_type   cfg_ff, cfg_in;
   btf_entry_type push_entry;
   btf_entry_type head;
   logic          push;
   logic          pop;
   logic          q_full;
   logic          q_empty;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_BASE_TONE:    cfg_in.base_tone         = csr_ch.wdata;
            REG_TONE_STEP:    cfg_in.tone_step         = csr_ch.wdata[STEP_W-1:0];
            REG_START_GUARD:  cfg_in.start_guard_tone  = csr_ch.wdata;
            REG_SECOND_GUARD: cfg_in.second_guard_tone = csr_ch.wdata;
            REG_SEPARATOR:    cfg_in.separator_tone    = csr_ch.wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_tone         <= RST_BASE_TONE;
         cfg_ff.tone_step         <= RST_TONE_STEP;
         cfg_ff.start_guard_tone  <= RST_START_GUARD;
         cfg_ff.second_guard_tone <= RST_SECOND_GUARD;
         cfg_ff.separator_tone    <= RST_SEPARATOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   btf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   btf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .empty      (q_empty),
      .head       (head)
   );

   btf_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .empty  (q_empty),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );
endmodule
`default_nettype wire

@@ hw/rtl/btf_front.sv @@
`default_nettype none
module btf_front (
   input  logic                  clock,
   input  logic                  reset,
   btf_req_if.sink               req_ch,
   input  btf_pkg::btf_cfg_type  cfg,
   input  logic                  q_full,
   output logic                  push,
   output btf_pkg::btf_entry_type push_entry
);
   import btf_pkg::*;

   logic                  busy_ff, busy_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [SLOTS-1:0]      en_ff, en_in;
   logic [BYTE_W-1:0]     data_ff, data_in;
   logic [BYTE_W-1:0]     len_ff, len_in;

   logic [SLOTS-1:0]      req_en;
   logic [SLOT_W-1:0]     first_slot;
   logic [SLOT_W-1:0]     next_slot;
   logic                  has_next;
   logic                  accept;
   logic [CHUNK_BITS-1:0] dchunk [CHUNKS];
   logic [CHUNK_BITS-1:0] sel_chunk;
   logic [CIDX_W-1:0]     didx;
   logic [TONE_W-1:0]     tone;

   always_comb begin
      req_en = '0;
      req_en[SLOT_GUARD]  = req_ch.start_of_message;
      req_en[SLOT_SECOND] = req_ch.start_of_message;
      req_en[SLOT_LEN0]   = req_ch.start_of_message;
      req_en[SLOT_LEN1]   = req_ch.start_of_message;
      for (int i = 0; i < CHUNKS; i++) begin
         req_en[SLOT_DATA + i] = req_ch.has_data;
      end
      req_en[SLOT_END] = req_ch.end_of_message;
      first_slot = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (req_en[i]) begin
            first_slot = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      next_slot = slot_ff;
      has_next  = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (en_ff[i] && (SLOT_W'(i) > slot_ff)) begin
            next_slot = SLOT_W'(i);
            has_next  = 1'b1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < CHUNKS; i++) begin
         dchunk[i] = data_ff[BYTE_W - CHUNK_BITS - i * CHUNK_BITS +: CHUNK_BITS];
      end
      didx = CIDX_W'(slot_ff - SLOT_W'(SLOT_DATA));
      case (slot_ff) inside
         SLOT_W'(SLOT_LEN0): sel_chunk = len_ff[BYTE_W - CHUNK_BITS +: CHUNK_BITS];
         SLOT_W'(SLOT_LEN1): sel_chunk = len_ff[BYTE_W - 2 * CHUNK_BITS +: CHUNK_BITS];
         default:            sel_chunk = dchunk[didx];
      endcase
      tone = chunk_tone(sel_chunk, cfg.base_tone, cfg.tone_step);
      case (slot_ff) inside
         SLOT_W'(SLOT_GUARD), SLOT_W'(SLOT_END): push_entry.tone = cfg.start_guard_tone;
         SLOT_W'(SLOT_SECOND):                   push_entry.tone = cfg.second_guard_tone;
         default:                                push_entry.tone = tone;
      endcase
      push_entry.last  = !has_next;
      push_entry.fresh = (slot_ff == SLOT_W'(SLOT_GUARD));
   end

   assign push         = busy_ff && !q_full;
   assign req_ch.ready = !busy_ff || (push && !has_next);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      busy_in = busy_ff;
      slot_in = slot_ff;
      en_in   = en_ff;
      data_in = data_ff;
      len_in  = len_ff;
      if (push) begin
         if (has_next) begin
            slot_in = next_slot;
         end else begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in = |req_en;
         slot_in = first_slot;
         en_in   = req_en;
         data_in = req_ch.data_byte;
         len_in  = req_ch.message_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      slot_ff <= slot_in;
      en_ff   <= en_in;
      data_ff <= data_in;
      len_ff  <= len_in;
   end
endmodule
`default_nettype wire

@@ hw/rtl/btf_queue.sv @@
`default_nettype none
module btf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  btf_pkg::btf_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output btf_pkg::btf_entry_type head
);
   import btf_pkg::*;

   btf_entry_type        mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wptr_ff, wptr_in;
   logic [Q_PTR_W-1:0]   rptr_ff, rptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         mem_ff[wptr_ff] <= push_entry;
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/btf_back.sv @@
`default_nettype none
module btf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  btf_pkg::btf_cfg_type   cfg,
   input  logic                   empty,
   input  btf_pkg::btf_entry_type head,
   output logic                   pop,
   btf_rsp_if.source              rsp_ch
);
   import btf_pkg::*;

   logic              prev_valid_ff, prev_valid_in;
   logic [TONE_W-1:0] prev_tone_ff, prev_tone_in;
   logic              sep_done_ff, sep_done_in;
   logic              out_valid_ff, out_valid_in;
   logic [TONE_W-1:0] out_tone_ff, out_tone_in;
   logic              out_last_ff, out_last_in;
   logic              load;
   logic              dup;

   assign load = !out_valid_ff || rsp_ch.ready;
   assign dup  = prev_valid_ff && !head.fresh && (prev_tone_ff == head.tone) && !sep_done_ff;
   assign pop  = load && !empty && !dup;

   always_comb begin
      prev_valid_in = prev_valid_ff;
      prev_tone_in  = prev_tone_ff;
      sep_done_in   = sep_done_ff;
      out_valid_in  = out_valid_ff;
      out_tone_in   = out_tone_ff;
      out_last_in   = out_last_ff;
      if (load) begin
         out_valid_in = !empty;
         if (!empty) begin
            if (dup) begin
               out_tone_in = cfg.separator_tone;
               out_last_in = 1'b0;
               sep_done_in = 1'b1;
            end else begin
               out_tone_in   = head.tone;
               out_last_in   = head.last;
               sep_done_in   = 1'b0;
               prev_tone_in  = head.tone;
               prev_valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
         prev_tone_ff  <= '0;
         sep_done_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prev_valid_ff <= prev_valid_in;
         prev_tone_ff  <= prev_tone_in;
         sep_done_ff   <= sep_done_in;
         out_valid_ff  <= out_valid_in;
      end
      out_tone_ff <= out_tone_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.tone        = out_tone_ff;
   assign rsp_ch.last_of_run = out_last_ff;
endmodule
`default_nettype wire
